FILE: rtl/stfm_pkg.sv
`timescale 1ns / 1ps

package stfm_pkg;

  // Packed widths of the stream payloads.
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  // Output tdata layout, lowest bit up.
  localparam int OUT_FRAME_LSB = 0;
  localparam int OUT_DESC_LSB  = 12;
  localparam int OUT_EW_BIT    = 44;
  localparam int OUT_IV_BIT    = 45;
  localparam int OUT_IADDR_LSB = 46;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_NO_FREE  = 2'd2;
  localparam logic [1:0] STAT_TOO_LONG = 2'd3;

  // Fixed descriptor bits: section type and full access permissions.
  localparam logic [31:0] DESC_SECTION = 32'h0000_0002;
  localparam logic [31:0] DESC_AP      = 32'h0000_0C00;

  typedef enum logic [2:0] {
    FN_ENABLE  = 3'd0,
    FN_ALLOC   = 3'd1,
    FN_FREE    = 3'd2,
    FN_DISABLE = 3'd3,
    FN_MAP     = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EN_CALC,
    ST_EN_CHK,
    ST_EN_RD,
    ST_EN_EVAL,
    ST_AL_RD,
    ST_AL_EVAL,
    ST_OP_RD,
    ST_OP_EVAL
  } state_t;

  // Access request from the sequencer to the frame store.
  typedef struct packed {
    logic        bm_rd;
    logic [6:0]  bm_rd_row;
    logic        bm_wr;
    logic [6:0]  bm_wr_row;
    logic [31:0] bm_wr_data;
    logic        ty_rd;
    logic [11:0] ty_rd_addr;
    logic        ty_wr;
    logic [11:0] ty_wr_addr;
    logic [1:0]  ty_wr_data;
  } stfm_req_t;

  // Registered read data and clearing status from the frame store.
  typedef struct packed {
    logic        clear_busy;
    logic [31:0] bm_rd_data;
    logic [1:0]  ty_rd_data;
  } stfm_rsp_t;

  // TEX/C/B bits for a memory type; type 3 aliases write-combine.
  function automatic logic [31:0] tex_bits(logic [1:0] ty);
    logic [31:0] t;
    unique case (ty)
      2'd0:    t = 32'h0;
      2'd2:    t = 32'h8;
      default: t = 32'h4;
    endcase
    return t;
  endfunction

  function automatic logic [31:0] make_desc(logic [31:0] addr, logic [1:0] ty, logic sh);
    return addr | DESC_SECTION | DESC_AP | {15'd0, sh, 16'd0} | tex_bits(ty);
  endfunction

  // Binary index of a one-hot word; each output bit is an independent OR.
  function automatic logic [4:0] onehot_index(logic [31:0] oh);
    logic [4:0] idx;
    idx = 5'd0;
    for (int b = 0; b < 5; b++) begin
      for (int i = 0; i < 32; i++) begin
        if (((i >> b) & 1) == 1) begin
          idx[b] = idx[b] | oh[i];
        end
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/stfm_store.sv
`timescale 1ns / 1ps

module stfm_store
  import stfm_pkg::*;
#(
  parameter int NUM_FRAMES = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  stfm_req_t req,
  output stfm_rsp_t rsp
);

  localparam int ROWS = (NUM_FRAMES + 31) / 32;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FW   = $clog2(NUM_FRAMES);

  // Allocation bitmap, 32 frames per row, and the per-frame memory type.
  logic [31:0] bm_mem [ROWS];
  logic [1:0]  ty_mem [NUM_FRAMES];

  logic [31:0] bm_rd_data_r;
  logic [1:0]  ty_rd_data_r;
  logic        busy_r;
  logic [FW-1:0] clr_r;

  logic clr_row_ok;
  assign clr_row_ok = ({1'b0, clr_r} < (FW + 1)'(ROWS));

  // Clearing pass after reset, one frame per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      if (clr_r == FW'(NUM_FRAMES - 1)) begin
        busy_r <= 1'b0;
      end
      clr_r <= clr_r + 1'b1;
    end
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (clr_row_ok) begin
        bm_mem[clr_r[RW-1:0]] <= '0;
      end
    end else if (req.bm_wr) begin
      bm_mem[req.bm_wr_row[RW-1:0]] <= req.bm_wr_data;
    end
    if (req.bm_rd) begin
      bm_rd_data_r <= bm_mem[req.bm_rd_row[RW-1:0]];
    end
  end

  // Type memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      ty_mem[clr_r] <= 2'd0;
    end else if (req.ty_wr) begin
      ty_mem[req.ty_wr_addr[FW-1:0]] <= req.ty_wr_data;
    end
    if (req.ty_rd) begin
      ty_rd_data_r <= ty_mem[req.ty_rd_addr[FW-1:0]];
    end
  end

  assign rsp.clear_busy = busy_r;
  assign rsp.bm_rd_data = bm_rd_data_r;
  assign rsp.ty_rd_data = ty_rd_data_r;

endmodule

FILE: rtl/section_table_frame_manager_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                          Contents
// in       slave      in_tvalid/in_tready/in_tdata   one operation request
//                     in_tuser                       operation code
// out      master     out_tvalid/out_tready/out_tdata one result
//                     out_tuser, out_tlast           status, final result of a request
//
// One request is worked at a time; in_tready is high only in the idle state, so the sequencer
// takes no new request until it is through with the last. Free, disable and map pass through a
// read and an evaluate state; alloc passes through both once per 32-frame bitmap row scanned
// (up to ceil(NUM_FRAMES / 32) rows), for the read-modify-write of the bitmap memory. Enable range
// passes through calc and check states, then a read and an evaluate state per section. After
// reset a clearing pass holds in_tready low. A stalled result holds the sequencer in its check or evaluate state.
module section_table_frame_manager_unit
  import stfm_pkg::*;
#(
  parameter int NUM_FRAMES    = 4096,
  parameter int SECTION_SHIFT = 20,
  parameter int MAX_RUN       = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // phys_addr[31:0], byte_length[63:32], frame[75:64], mem_type[77:76],
  // shareable[78], zero[79]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // frame_out[11:0], descriptor[43:12], entry_written[44], invalidate_valid[45],
  // invalidate_addr[77:46], zero[79:78]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int ROWS      = (NUM_FRAMES + 31) / 32;
  localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LAST_BITS = NUM_FRAMES - (ROWS - 1) * 32;
  localparam int ES_W      = 34 - SECTION_SHIFT;
  localparam logic [31:0] PAD_MASK = 32'(~((64'd1 << LAST_BITS) - 64'd1));
  localparam logic [33:0] SEC_ROUND = 34'((64'd1 << SECTION_SHIFT) - 64'd1);
  localparam logic [33:0] TOP_SEC   = 34'(64'd1 << (32 - SECTION_SHIFT));

  stfm_req_t req;
  stfm_rsp_t rsp;

  stfm_store #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  state_t state_r, state_nxt;

  // Request fields held for the whole operation.
  func_t       func_r, func_nxt;
  logic [31:0] pa_r, pa_nxt;
  logic [31:0] len_r, len_nxt;
  logic [11:0] frame_r, frame_nxt;
  logic [1:0]  type_r, type_nxt;
  logic        sh_r, sh_nxt;

  // Run and search bookkeeping.
  logic [ES_W-1:0] end_sec_r, end_sec_nxt;
  logic [11:0]     fr_r, fr_nxt;
  logic [6:0]      rem_r, rem_nxt;
  logic [RW-1:0]   al_row_r, al_row_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  o_status_r, o_status_nxt;
  logic [11:0] o_frame_r, o_frame_nxt;
  logic [31:0] o_desc_r, o_desc_nxt;
  logic        o_ew_r, o_ew_nxt;
  logic        o_iv_r, o_iv_nxt;
  logic [31:0] o_iaddr_r, o_iaddr_nxt;
  logic        o_last_r, o_last_nxt;

  logic accept;
  logic out_free;
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Range setup: rounded end section, first section and section count.
  logic [33:0]     round_sum;
  logic [ES_W-1:0] first_sec;
  logic [ES_W-1:0] num_sec;
  logic            chk_empty;
  logic            chk_too_long;
  assign round_sum = {2'b00, pa_r} + {2'b00, len_r} + SEC_ROUND;
  assign first_sec = ES_W'(pa_r[31:SECTION_SHIFT]);
  assign num_sec   = end_sec_r - first_sec;
  assign chk_empty = (num_sec == '0);
  assign chk_too_long = (34'(num_sec) > 34'(MAX_RUN)) ||
                        (34'(end_sec_r) > 34'(NUM_FRAMES)) ||
                        (34'(end_sec_r) > TOP_SEC);

  // Per-section evaluation of the bitmap and type read back.
  logic [31:0] fr_onehot;
  logic        en_taken;
  logic        en_conflict;
  logic        en_last;
  logic [43:0] en_addr_w;
  logic [31:0] en_addr;
  assign fr_onehot   = 32'd1 << fr_r[4:0];
  assign en_taken    = rsp.bm_rd_data[fr_r[4:0]];
  assign en_conflict = en_taken && (rsp.ty_rd_data != type_r);
  assign en_last     = (rem_r == 7'd1);
  assign en_addr_w   = {32'd0, fr_r} << SECTION_SHIFT;
  assign en_addr     = en_addr_w[31:0];

  // Alloc search: lowest zero in the row, padding frames count as taken.
  logic        al_last_row;
  logic [31:0] al_word;
  logic [31:0] al_onehot;
  logic        al_has_free;
  logic [11:0] al_frame;
  assign al_last_row = (al_row_r == RW'(ROWS - 1));
  assign al_word     = rsp.bm_rd_data | (al_last_row ? PAD_MASK : 32'd0);
  assign al_onehot   = ~al_word & (al_word + 32'd1);
  assign al_has_free = ~&al_word;
  assign al_frame    = 12'({al_row_r, onehot_index(al_onehot)});

  // Single-frame operations.
  logic        op_in_range;
  logic [31:0] op_bit;
  logic [43:0] op_addr_w;
  logic [31:0] op_addr;
  assign op_in_range = ({1'b0, frame_r} < 13'(NUM_FRAMES));
  assign op_bit      = 32'd1 << frame_r[4:0];
  assign op_addr_w   = {32'd0, frame_r} << SECTION_SHIFT;
  assign op_addr     = op_addr_w[31:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (!rsp.clear_busy) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_tuser))
            FN_ENABLE:                  state_nxt = ST_EN_CALC;
            FN_ALLOC:                   state_nxt = ST_AL_RD;
            FN_FREE, FN_DISABLE, FN_MAP: state_nxt = ST_OP_RD;
            default:                    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EN_CALC: state_nxt = ST_EN_CHK;
      ST_EN_CHK: begin
        priority if (chk_empty) state_nxt = ST_IDLE;
        else if (chk_too_long) state_nxt = out_free ? ST_IDLE : ST_EN_CHK;
        else state_nxt = ST_EN_RD;
      end
      ST_EN_RD: state_nxt = ST_EN_EVAL;
      ST_EN_EVAL: begin
        if (out_free) state_nxt = (en_conflict || en_last) ? ST_IDLE : ST_EN_RD;
      end
      ST_AL_RD: state_nxt = ST_AL_EVAL;
      ST_AL_EVAL: begin
        if (al_has_free || al_last_row) state_nxt = out_free ? ST_IDLE : ST_AL_EVAL;
        else state_nxt = ST_AL_RD;
      end
      ST_OP_RD: state_nxt = ST_OP_EVAL;
      ST_OP_EVAL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers and the result load.
  always_comb begin
    func_nxt    = func_r;
    pa_nxt      = pa_r;
    len_nxt     = len_r;
    frame_nxt   = frame_r;
    type_nxt    = type_r;
    sh_nxt      = sh_r;
    end_sec_nxt = end_sec_r;
    fr_nxt      = fr_r;
    rem_nxt     = rem_r;
    al_row_nxt  = al_row_r;

    out_valid_nxt = out_valid_r && !out_tready;
    o_status_nxt  = o_status_r;
    o_frame_nxt   = o_frame_r;
    o_desc_nxt    = o_desc_r;
    o_ew_nxt      = o_ew_r;
    o_iv_nxt      = o_iv_r;
    o_iaddr_nxt   = o_iaddr_r;
    o_last_nxt    = o_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt   = func_t'(in_tuser);
          pa_nxt     = in_tdata[31:0];
          len_nxt    = in_tdata[63:32];
          frame_nxt  = in_tdata[75:64];
          type_nxt   = in_tdata[77:76];
          sh_nxt     = in_tdata[78];
          al_row_nxt = '0;
        end
      end
      ST_EN_CALC: begin
        end_sec_nxt = round_sum[33:SECTION_SHIFT];
      end
      ST_EN_CHK: begin
        fr_nxt  = 12'(first_sec);
        rem_nxt = 7'(num_sec);
        if (!chk_empty && chk_too_long && out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = STAT_TOO_LONG;
          o_frame_nxt   = 12'(first_sec);
          o_desc_nxt    = '0;
          o_ew_nxt      = 1'b0;
          o_iv_nxt      = 1'b0;
          o_iaddr_nxt   = '0;
          o_last_nxt    = 1'b1;
        end
      end
      ST_EN_EVAL: begin
        if (out_free) begin
          fr_nxt        = fr_r + 12'd1;
          rem_nxt       = rem_r - 7'd1;
          out_valid_nxt = 1'b1;
          o_frame_nxt   = fr_r;
          priority if (en_conflict) begin
            o_status_nxt = STAT_MISMATCH;
            o_desc_nxt   = '0;
            o_ew_nxt     = 1'b0;
            o_iv_nxt     = 1'b0;
            o_iaddr_nxt  = '0;
            o_last_nxt   = 1'b1;
          end else if (en_taken) begin
            o_status_nxt = STAT_OK;
            o_desc_nxt   = '0;
            o_ew_nxt     = 1'b0;
            o_iv_nxt     = 1'b0;
            o_iaddr_nxt  = '0;
            o_last_nxt   = en_last;
          end else begin
            o_status_nxt = STAT_OK;
            o_desc_nxt   = make_desc(en_addr, type_r, sh_r);
            o_ew_nxt     = 1'b1;
            o_iv_nxt     = 1'b1;
            o_iaddr_nxt  = en_addr;
            o_last_nxt   = en_last;
          end
        end
      end
      ST_AL_EVAL: begin
        if (al_has_free || al_last_row) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            o_status_nxt  = al_has_free ? STAT_OK : STAT_NO_FREE;
            o_frame_nxt   = al_has_free ? al_frame : 12'd0;
            o_desc_nxt    = '0;
            o_ew_nxt      = 1'b0;
            o_iv_nxt      = 1'b0;
            o_iaddr_nxt   = '0;
            o_last_nxt    = 1'b1;
          end
        end else begin
          al_row_nxt = al_row_r + 1'b1;
        end
      end
      ST_OP_EVAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = STAT_OK;
          o_frame_nxt   = frame_r;
          o_ew_nxt      = op_in_range;
          o_iv_nxt      = op_in_range;
          o_last_nxt    = 1'b1;
          o_desc_nxt    = '0;
          o_iaddr_nxt   = '0;
          if (op_in_range) begin
            if (func_r == FN_MAP) begin
              o_desc_nxt  = make_desc(pa_r, type_r, sh_r);
              o_iaddr_nxt = pa_r;
            end else begin
              o_iaddr_nxt = op_addr;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Memory requests: reads ahead of each evaluate state, writes as results go out.
  always_comb begin
    req = '0;
    unique case (state_r)
      ST_EN_RD: begin
        req.bm_rd      = 1'b1;
        req.bm_rd_row  = fr_r[11:5];
        req.ty_rd      = 1'b1;
        req.ty_rd_addr = fr_r;
      end
      ST_EN_EVAL: begin
        if (out_free && !en_taken) begin
          req.bm_wr      = 1'b1;
          req.bm_wr_row  = fr_r[11:5];
          req.bm_wr_data = rsp.bm_rd_data | fr_onehot;
          req.ty_wr      = 1'b1;
          req.ty_wr_addr = fr_r;
          req.ty_wr_data = type_r;
        end
      end
      ST_AL_RD: begin
        req.bm_rd     = 1'b1;
        req.bm_rd_row = 7'(al_row_r);
      end
      ST_AL_EVAL: begin
        if (al_has_free && out_free) begin
          req.bm_wr      = 1'b1;
          req.bm_wr_row  = 7'(al_row_r);
          req.bm_wr_data = rsp.bm_rd_data | al_onehot;
        end
      end
      ST_OP_RD: begin
        if (op_in_range && func_r == FN_FREE) begin
          req.bm_rd     = 1'b1;
          req.bm_rd_row = frame_r[11:5];
        end
      end
      ST_OP_EVAL: begin
        if (out_free && op_in_range) begin
          if (func_r == FN_FREE) begin
            req.bm_wr      = 1'b1;
            req.bm_wr_row  = frame_r[11:5];
            req.bm_wr_data = rsp.bm_rd_data & ~op_bit;
          end
          if (func_r == FN_MAP) begin
            req.ty_wr      = 1'b1;
            req.ty_wr_addr = frame_r;
            req.ty_wr_data = type_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    pa_r       <= pa_nxt;
    len_r      <= len_nxt;
    frame_r    <= frame_nxt;
    type_r     <= type_nxt;
    sh_r       <= sh_nxt;
    end_sec_r  <= end_sec_nxt;
    fr_r       <= fr_nxt;
    rem_r      <= rem_nxt;
    al_row_r   <= al_row_nxt;
    o_status_r <= o_status_nxt;
    o_frame_r  <= o_frame_nxt;
    o_desc_r   <= o_desc_nxt;
    o_ew_r     <= o_ew_nxt;
    o_iv_r     <= o_iv_nxt;
    o_iaddr_r  <= o_iaddr_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_iaddr_r, o_iv_r, o_ew_r, o_desc_r, o_frame_r};

endmodule

FILE: rtl/stfm_checker.sv
`timescale 1ns / 1ps

module stfm_checker
  import stfm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Any status other than ok closes the request.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_OK |-> out_tlast)
    else $error("error status without last");

  // Every table write comes with a TLB invalidate and vice versa.
  a_wr_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_EW_BIT] == out_tdata[OUT_IV_BIT])
    else $error("entry write and invalidate disagree");

  // Fields that are not flagged read as zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_EW_BIT] |->
      out_tdata[OUT_DESC_LSB +: 32] == 32'd0 && out_tdata[OUT_IADDR_LSB +: 32] == 32'd0)
    else $error("unflagged descriptor or address not zero");

  // The clearing pass keeps requests out right after reset.
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("request taken during clearing pass");

endmodule

bind section_table_frame_manager_unit stfm_checker u_stfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
